// ===== rtl/spitx_pkg.sv =====
`default_nettype none

package spitx_pkg;

	localparam int NUM_CH         = 3;
	localparam int CH_W           = 2;
	localparam int BYTE_W         = 8;
	localparam int FIFO_DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		CMD_PUSH     = 2'd0,
		CMD_CLOSE    = 2'd1,
		CMD_TX_READY = 2'd2,
		CMD_RX_BYTE  = 2'd3
	} cmd_t;

	typedef enum logic {
		STATUS_OK     = 1'b0,
		STATUS_BAD_CH = 1'b1
	} status_t;

	localparam logic [NUM_CH-1:0] SEL_IDLE = {NUM_CH{1'b1}};

	// everything of one result word except the popped byte, which comes from the ram
	typedef struct packed {
		status_t             status;
		logic                send_valid;
		logic                rx_valid;
		logic [BYTE_W-1:0]   rx_out;
		logic [NUM_CH-1:0]   select_lines;
		logic                finalize;
		logic                tx_enabled;
		logic                polling;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/spitx_in_if.sv =====
`default_nettype none

interface spitx_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [1:0] channel;
	logic [7:0] data_byte;
	logic       bus_busy;

	modport source (output valid, output cmd, output channel, output data_byte,
		output bus_busy, input ready);
	modport sink (input valid, input cmd, input channel, input data_byte,
		input bus_busy, output ready);
endinterface

`default_nettype wire

// ===== rtl/spitx_out_if.sv =====
`default_nettype none

interface spitx_out_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       rx_valid;
	logic [7:0] rx_out;
	logic [2:0] select_lines;
	logic       finalize;
	logic       tx_enabled;
	logic       polling;

	modport source (output valid, output status, output send_valid, output send_byte,
		output rx_valid, output rx_out, output select_lines, output finalize,
		output tx_enabled, output polling, input ready);
	modport sink (input valid, input status, input send_valid, input send_byte,
		input rx_valid, input rx_out, input select_lines, input finalize,
		input tx_enabled, input polling, output ready);
endinterface

`default_nettype wire

// ===== rtl/spitx_ram.sv =====
`default_nettype none

module spitx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/spitx_sched.sv =====
`default_nettype none

module spitx_sched #(
	parameter int FIFO_DEPTH = spitx_pkg::FIFO_DEPTH_DEF,
	localparam int AW = $clog2(spitx_pkg::NUM_CH * FIFO_DEPTH)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                go,
	input  wire logic [1:0]                          cmd,
	input  wire logic [spitx_pkg::CH_W-1:0]          channel,
	input  wire logic [spitx_pkg::BYTE_W-1:0]        data_byte,
	input  wire logic                                bus_busy,
	output spitx_pkg::res_t                          res,
	output logic                                     ram_we,
	output logic      [AW-1:0]                       ram_waddr,
	output logic      [spitx_pkg::BYTE_W-1:0]        ram_wdata,
	output logic                                     ram_re,
	output logic      [AW-1:0]                       ram_raddr
);

	localparam int NCH = spitx_pkg::NUM_CH;
	localparam int PW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW  = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);
	localparam logic [AW-1:0] BANK     = AW'(FIFO_DEPTH);

	logic [PW-1:0]               head_q [NCH];
	logic [PW-1:0]               tail_q [NCH];
	logic [CW-1:0]               count_q [NCH];
	logic [NCH-1:0]              busy_q;
	logic [spitx_pkg::CH_W-1:0]  cur_q;
	logic                        round_q;
	logic [NCH-1:0]              sel_q;
	logic                        tx_on_q;

	logic [PW-1:0]               head_n [NCH];
	logic [PW-1:0]               tail_n [NCH];
	logic [CW-1:0]               count_n [NCH];
	logic [NCH-1:0]              busy_n;
	logic [spitx_pkg::CH_W-1:0]  cur_n;
	logic                        round_n;
	logic [NCH-1:0]              sel_n;
	logic                        tx_on_n;

	spitx_pkg::cmd_t             op;
	logic                        ch_ok;
	logic                        tx_ev;
	logic                        rx_ev;
	logic                        push_ok;
	logic                        found;
	logic [spitx_pkg::CH_W-1:0]  pick;
	logic [NCH-1:0]              clr;
	logic [PW-1:0]               tail_sel;
	logic [PW-1:0]               head_sel;
	logic [CW-1:0]               count_sel;

	always_comb begin
		op      = spitx_pkg::cmd_t'(cmd);
		ch_ok   = channel < spitx_pkg::CH_W'(NCH);
		tx_ev   = (op == spitx_pkg::CMD_TX_READY) && !bus_busy && tx_on_q;
		rx_ev   = (op == spitx_pkg::CMD_RX_BYTE) && !bus_busy;

		// per-channel pointers picked by the addressed channel
		tail_sel  = '0;
		count_sel = '0;
		for (int c = 0; c < NCH; c++) begin
			if (channel == spitx_pkg::CH_W'(c)) begin
				tail_sel  = tail_q[c];
				count_sel = count_q[c];
			end
		end
		push_ok = (op == spitx_pkg::CMD_PUSH) && ch_ok && !busy_q[channel]
			&& (count_sel != CNT_FULL);

		// first non-empty channel from the current one up to the last
		found = 1'b0;
		pick  = '0;
		for (int c = NCH - 1; c >= 0; c--) begin
			if (spitx_pkg::CH_W'(c) >= cur_q && count_q[c] != '0) begin
				found = 1'b1;
				pick  = spitx_pkg::CH_W'(c);
			end
		end
		head_sel = '0;
		for (int c = 0; c < NCH; c++) begin
			clr[c] = spitx_pkg::CH_W'(c) >= cur_q && (!found || spitx_pkg::CH_W'(c) < pick);
			if (pick == spitx_pkg::CH_W'(c)) begin
				head_sel = head_q[c];
			end
		end

		busy_n  = busy_q;
		cur_n   = cur_q;
		round_n = round_q;
		sel_n   = sel_q;
		tx_on_n = tx_on_q;
		res     = '0;

		if ((op == spitx_pkg::CMD_PUSH || op == spitx_pkg::CMD_CLOSE) && !ch_ok) begin
			res.status = spitx_pkg::STATUS_BAD_CH;
		end
		if (op == spitx_pkg::CMD_CLOSE && ch_ok) begin
			busy_n[channel] = 1'b1;
			tx_on_n         = 1'b1;
		end
		if (rx_ev) begin
			res.rx_valid = 1'b1;
			res.rx_out   = data_byte;
			res.finalize = !round_q;
		end
		if (tx_ev) begin
			busy_n = busy_q & ~clr;
			cur_n  = found ? pick : '0;
			sel_n  = (|clr) ? spitx_pkg::SEL_IDLE : sel_q;
			if (found) begin
				sel_n[pick]    = 1'b0;
				round_n        = 1'b1;
				res.send_valid = 1'b1;
			end
			if (busy_n == '0) begin
				tx_on_n      = 1'b0;
				round_n      = 1'b0;
				res.finalize = 1'b1;
			end
		end

		res.select_lines = sel_n;
		res.tx_enabled   = tx_on_n;
		res.polling      = round_n;

		for (int c = 0; c < NCH; c++) begin
			head_n[c]  = head_q[c];
			tail_n[c]  = tail_q[c];
			count_n[c] = count_q[c];
			if (push_ok && channel == spitx_pkg::CH_W'(c)) begin
				tail_n[c]  = (tail_q[c] == PTR_LAST) ? '0 : tail_q[c] + PW'(1);
				count_n[c] = count_q[c] + CW'(1);
			end
			if (tx_ev && found && pick == spitx_pkg::CH_W'(c)) begin
				head_n[c]  = (head_q[c] == PTR_LAST) ? '0 : head_q[c] + PW'(1);
				count_n[c] = count_q[c] - CW'(1);
			end
		end

		ram_we    = go && push_ok;
		ram_waddr = AW'(channel) * BANK + AW'(tail_sel);
		ram_wdata = data_byte;
		ram_re    = go && tx_ev && found;
		ram_raddr = AW'(pick) * BANK + AW'(head_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				head_q[c]  <= '0;
				tail_q[c]  <= '0;
				count_q[c] <= '0;
			end
			busy_q  <= '0;
			cur_q   <= '0;
			round_q <= 1'b0;
			sel_q   <= spitx_pkg::SEL_IDLE;
			tx_on_q <= 1'b0;
		end else if (go) begin
			for (int c = 0; c < NCH; c++) begin
				head_q[c]  <= head_n[c];
				tail_q[c]  <= tail_n[c];
				count_q[c] <= count_n[c];
			end
			busy_q  <= busy_n;
			cur_q   <= cur_n;
			round_q <= round_n;
			sel_q   <= sel_n;
			tx_on_q <= tx_on_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/three_channel_spi_tx_scheduler.sv =====
// three-channel spi transmit scheduler
//
// req carries command words: push a packet byte, close a packet, transmit
// ready event, received byte. rsp returns exactly one result word for every
// command word, in order: status, the byte handed to the shifter, the byte
// forwarded to the collector, chip select levels, finalize, tx enable and
// the polling flag.
// each command word accepted on req is registered in the input stage and then
// in the result stage, whose register drives rsp. one word a cycle is taken
// and delivered when rsp is not stalled; per word the scheduler makes one
// state update plus at most one fifo ram access.
// the three channel fifos share one ram of 3 x FIFO_DEPTH bytes, with the
// popped byte coming straight out of the ram's read register.
// reset clears pointers, counts, busy flags and the round, deselects all
// chip selects and disables transmission; ram contents are left alone and
// only entries that were pushed are ever read, so no clearing pass runs.
// when rsp stalls the result register holds, the word in the input stage
// waits, and req drops ready once that stage is occupied.
`default_nettype none

module three_channel_spi_tx_scheduler #(
	parameter int FIFO_DEPTH = spitx_pkg::FIFO_DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	spitx_in_if.sink   req,
	spitx_out_if.source rsp
);

	localparam int RAM_DEPTH = spitx_pkg::NUM_CH * FIFO_DEPTH;
	localparam int AW        = $clog2(RAM_DEPTH);

	// input stage
	logic                             valid_s1;
	logic [1:0]                       cmd_s1;
	logic [spitx_pkg::CH_W-1:0]       channel_s1;
	logic [spitx_pkg::BYTE_W-1:0]     data_s1;
	logic                             bus_busy_s1;

	// result stage
	logic                             valid_s2;
	spitx_pkg::res_t                  res_s2;

	spitx_pkg::res_t                  res_n;
	logic                             adv;
	logic                             take;
	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [spitx_pkg::BYTE_W-1:0]     ram_wdata;
	logic                             ram_re;
	logic [AW-1:0]                    ram_raddr;
	logic [spitx_pkg::BYTE_W-1:0]     ram_rdata;

	// stage 1 moves on when the result register is free or being drained
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1      <= req.cmd;
			channel_s1  <= req.channel;
			data_s1     <= req.data_byte;
			bus_busy_s1 <= req.bus_busy;
		end
	end

	spitx_sched #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (adv),
		.cmd       (cmd_s1),
		.channel   (channel_s1),
		.data_byte (data_s1),
		.bus_busy  (bus_busy_s1),
		.res       (res_n),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	// popped byte lands in the ram read register alongside res_s2
	spitx_ram #(
		.WIDTH(spitx_pkg::BYTE_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_n;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.status       = res_s2.status;
	assign rsp.send_valid   = res_s2.send_valid;
	assign rsp.send_byte    = res_s2.send_valid ? ram_rdata : '0;
	assign rsp.rx_valid     = res_s2.rx_valid;
	assign rsp.rx_out       = res_s2.rx_out;
	assign rsp.select_lines = res_s2.select_lines;
	assign rsp.finalize     = res_s2.finalize;
	assign rsp.tx_enabled   = res_s2.tx_enabled;
	assign rsp.polling      = res_s2.polling;

	// a send and a forwarded byte never share one word
	a_send_rx_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.send_valid && rsp.rx_valid))
		else $error("send and receive in one result word");

	// a round can only run with transmission enabled
	a_poll_needs_tx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.polling |-> rsp.tx_enabled)
		else $error("polling without tx enabled");

	// a send leaves exactly the served chip select low
	a_send_one_cs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.send_valid |-> $onehot(~rsp.select_lines))
		else $error("send without a single active chip select");

	// a stalled input stage holds its word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(cmd_s1) && $stable(data_s1))
		else $error("input stage lost its word during a stall");

endmodule

`default_nettype wire
